FILE: design/sfe_pkg.sv
package sfe_pkg;

  localparam logic [7:0] BYTE_END = 8'hC0;
  localparam logic [7:0] BYTE_ESC = 8'hDB;
  localparam logic [7:0] SUB_END  = 8'hDC;
  localparam logic [7:0] SUB_ESC  = 8'hDD;
  localparam logic [7:0] TRAILER  = 8'hFF;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKED_FIRST  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKED_SECOND = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_APPEND_CSUM    = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       blocked;
  } out_t;

  typedef struct packed {
    logic       start;
    logic       held_valid;
    logic [7:0] held;
    logic       data_valid;
    logic [7:0] data;
    logic       csum_valid;
    logic [7:0] csum;
    logic       close;
    logic       notice;
  } cmd_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == BYTE_END) || (b == BYTE_ESC);
  endfunction

  function automatic logic [7:0] escape_code(input logic [7:0] b);
    return (b == BYTE_END) ? SUB_END : SUB_ESC;
  endfunction

endpackage

FILE: design/sfe_front.sv
module sfe_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  sfe_pkg::in_t                        item,
  input  logic                                queue_full,
  output logic                                cmd_push,
  output sfe_pkg::cmd_t                       cmd,
  input  logic                                cfg_valid,
  input  logic [sfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sfe_pkg::*;

  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_BODY   = 3'b100
  } pos_t;

  logic        block_enable;
  logic [15:0] blocked_first;
  logic [15:0] blocked_second;
  logic        append_csum;

  pos_t       pos, pos_next;
  logic [7:0] held, held_next;
  logic [7:0] sum, sum_next;
  logic       dropping, dropping_next;

  logic        accept;
  logic [15:0] code;
  logic        hit;
  logic [7:0]  body_sum;

  assign accept   = push && !queue_full;
  assign code     = {held, item.data_byte};
  assign hit      = block_enable && (code == blocked_first || code == blocked_second);
  assign body_sum = sum + item.data_byte;

  always_comb begin
    pos_next      = pos;
    held_next     = held;
    sum_next      = sum;
    dropping_next = dropping;
    cmd           = '0;
    cmd_push      = 1'b0;
    unique case (pos)
      POS_FIRST: begin
        if (item.last_byte) begin
          cmd.start      = 1'b1;
          cmd.data_valid = 1'b1;
          cmd.data       = item.data_byte;
          cmd.csum_valid = append_csum;
          cmd.csum       = 8'd0;
          cmd.close      = 1'b1;
          cmd_push       = 1'b1;
        end else begin
          held_next     = item.data_byte;
          sum_next      = 8'd0;
          dropping_next = 1'b0;
          pos_next      = POS_SECOND;
        end
      end
      POS_SECOND: begin
        if (hit) begin
          if (item.last_byte) begin
            cmd.notice = 1'b1;
            cmd_push   = 1'b1;
          end else begin
            dropping_next = 1'b1;
            pos_next      = POS_BODY;
          end
        end else begin
          cmd.start      = 1'b1;
          cmd.held_valid = 1'b1;
          cmd.held       = held;
          cmd.data_valid = 1'b1;
          cmd.data       = item.data_byte;
          cmd.csum_valid = append_csum && item.last_byte;
          cmd.csum       = item.data_byte;
          cmd.close      = item.last_byte;
          cmd_push       = 1'b1;
          sum_next       = item.data_byte;
          pos_next       = POS_BODY;
        end
      end
      default: begin
        if (dropping) begin
          cmd.notice = item.last_byte;
          cmd_push   = item.last_byte;
        end else begin
          cmd.data_valid = 1'b1;
          cmd.data       = item.data_byte;
          cmd.csum_valid = append_csum && item.last_byte;
          cmd.csum       = body_sum;
          cmd.close      = item.last_byte;
          cmd_push       = 1'b1;
          sum_next       = body_sum;
        end
      end
    endcase
    if (item.last_byte) begin
      pos_next      = POS_FIRST;
      held_next     = 8'd0;
      sum_next      = 8'd0;
      dropping_next = 1'b0;
    end
    if (!accept) begin
      cmd_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_FIRST;
      held     <= 8'd0;
      sum      <= 8'd0;
      dropping <= 1'b0;
    end else if (accept) begin
      pos      <= pos_next;
      held     <= held_next;
      sum      <= sum_next;
      dropping <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enable   <= 1'b0;
      blocked_first  <= 16'd0;
      blocked_second <= 16'd0;
      append_csum    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_ENABLE:   block_enable   <= cfg_data[0];
        CFG_BLOCKED_FIRST:  blocked_first  <= cfg_data;
        CFG_BLOCKED_SECOND: blocked_second <= cfg_data;
        CFG_APPEND_CSUM:    append_csum    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/sfe_cmd_fifo.sv
module sfe_cmd_fifo #(
  parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sfe_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output sfe_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import sfe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/sfe_back.sv
module sfe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  sfe_pkg::cmd_t queue_data,
  output logic          queue_pop,
  output logic          empty,
  input  logic          pop,
  output sfe_pkg::out_t result
);
  import sfe_pkg::*;

  cmd_t       cur, cur_next;
  logic       trail, trail_next;
  logic       esc_pend, esc_pend_next;
  logic [7:0] esc_byte, esc_byte_next;
  logic       out_valid;
  out_t       res;
  logic       busy;
  logic       done_next;
  logic       advance;
  logic       go;
  logic       load;

  assign busy = esc_pend || cur.start || cur.held_valid || cur.data_valid ||
                cur.csum_valid || cur.close || cur.notice || trail;
  assign advance = !out_valid || pop;
  assign go      = advance && busy;

  always_comb begin
    cur_next      = cur;
    trail_next    = trail;
    esc_pend_next = esc_pend;
    esc_byte_next = esc_byte;
    res           = '0;
    if (esc_pend) begin
      res.line_byte = esc_byte;
      esc_pend_next = 1'b0;
    end else if (cur.start) begin
      res.line_byte  = BYTE_END;
      cur_next.start = 1'b0;
    end else if (cur.held_valid) begin
      cur_next.held_valid = 1'b0;
      res.line_byte       = needs_escape(cur.held) ? BYTE_ESC : cur.held;
      esc_pend_next       = needs_escape(cur.held);
      esc_byte_next       = escape_code(cur.held);
    end else if (cur.data_valid) begin
      cur_next.data_valid = 1'b0;
      res.line_byte       = needs_escape(cur.data) ? BYTE_ESC : cur.data;
      esc_pend_next       = needs_escape(cur.data);
      esc_byte_next       = escape_code(cur.data);
    end else if (cur.csum_valid) begin
      cur_next.csum_valid = 1'b0;
      res.line_byte       = needs_escape(cur.csum) ? BYTE_ESC : cur.csum;
      esc_pend_next       = needs_escape(cur.csum);
      esc_byte_next       = escape_code(cur.csum);
    end else if (cur.close) begin
      res.line_byte  = BYTE_END;
      cur_next.close = 1'b0;
      trail_next     = 1'b1;
    end else if (trail) begin
      res.line_byte = TRAILER;
      res.frame_end = 1'b1;
      trail_next    = 1'b0;
    end else if (cur.notice) begin
      res.frame_end   = 1'b1;
      res.blocked     = 1'b1;
      cur_next.notice = 1'b0;
    end
    done_next = !(esc_pend_next || cur_next.start || cur_next.held_valid ||
                  cur_next.data_valid || cur_next.csum_valid || cur_next.close ||
                  cur_next.notice || trail_next);
  end

  assign load      = !busy || (go && done_next);
  assign queue_pop = load && !queue_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur       <= '0;
      trail     <= 1'b0;
      esc_pend  <= 1'b0;
      esc_byte  <= 8'd0;
    end else begin
      if (advance) begin
        out_valid <= go;
      end
      if (load) begin
        cur      <= queue_empty ? '0 : queue_data;
        trail    <= 1'b0;
        esc_pend <= 1'b0;
      end else if (go) begin
        cur      <= cur_next;
        trail    <= trail_next;
        esc_pend <= esc_pend_next;
        esc_byte <= esc_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result <= res;
    end
  end

endmodule

FILE: design/slip_frame_encoder_with_checksum_core.sv
// Path: an accepted item's command is written to the command queue, loaded into the back's
// current command register, and each line byte is registered on the result ports; line
// bytes follow one per cycle unless a result waits unpopped. Throughput: the front accepts
// one item per cycle while the command queue has room; an item yields zero to nine line
// bytes, and the command queue absorbs bursts in between.
// Reset: synchronous, clears packet state, queue and output valid; registers return to defaults.
module slip_frame_encoder_with_checksum_core #(
  parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  sfe_pkg::in_t                    item,
  input  logic                            pop,
  output logic                            empty,
  output sfe_pkg::out_t                   result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfe_pkg::*;

  logic cmd_push;
  cmd_t cmd;
  logic queue_pop;
  cmd_t queue_data;
  logic queue_empty;

  assign cfg_ready = 1'b1;

  sfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .queue_full (full),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sfe_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .rd_en   (queue_pop),
    .rd_data (queue_data),
    .full    (full),
    .empty   (queue_empty)
  );

  sfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_data  (queue_data),
    .queue_pop   (queue_pop),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule
